### sv/ibh_pkg.sv
// ----------------------------------------------------------------------------
// ibh_pkg
// Shared widths, register codes, taper tables and helpers for the impulse
// blanker with shaped hang.
// ----------------------------------------------------------------------------
package ibh_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int RING_DEPTH   = 16;
  localparam int RING_AW      = $clog2(RING_DEPTH);

  // configuration port
  localparam int THR_W     = 16;
  localparam int MODE_W    = 2;
  localparam int DLY_W     = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd845;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [DLY_W-1:0]  DLY_RESET  = 5'd2;
  localparam logic [DLY_W-1:0]  DELAY_MAX  = 5'd20;

  localparam logic [MODE_W-1:0] MODE_HANG3  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HANG7  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HANG15 = 2'd2;

  // pointers and hang count
  localparam int CNT_W  = 4;
  localparam int PTR_W  = 4;
  localparam int RPTR_W = 5;

  // running average, unsigned Q8.24
  localparam int AVG_W    = 32;
  localparam int AVG_FRAC = 16;
  localparam int AVGT_W   = AVG_W + AVG_FRAC + 2;
  localparam logic [AVG_W-1:0]  AVG_ONE    = 32'h0100_0000;
  localparam logic [AVGT_W-1:0] AVG_ROUND  = AVGT_W'(32768);

  // magnitude and its root
  localparam int CLIP_LEVEL = 167772;
  localparam int ROOT_STEPS = ($clog2(CLIP_LEVEL + 1) + 1) / 2;
  localparam int ROOT_BITS  = 2 * ROOT_STEPS;
  localparam int MAG_W      = ROOT_BITS;
  localparam int X_W        = 2 * ROOT_BITS;
  localparam int REM_W      = ROOT_BITS + 2;
  localparam logic [MAG_W-1:0] CLIP_MAG = MAG_W'(CLIP_LEVEL);

  localparam int SUM_W    = 2 * SAMPLE_WIDTH + 1;
  localparam int SQ_SHIFT = 50 - 2 * SAMPLE_WIDTH;
  localparam int SHX_W    = SUM_W + SQ_SHIFT;
  localparam longint unsigned CLIP_SQ =
    (longint'(CLIP_LEVEL) + 64'd1) * (longint'(CLIP_LEVEL) + 64'd1);
  localparam longint unsigned CLIP_SUM_L =
    (CLIP_SQ + (64'd1 << SQ_SHIFT) - 64'd1) >> SQ_SHIFT;
  localparam logic [SUM_W-1:0] CLIP_SUM = SUM_W'(CLIP_SUM_L);

  // digit-serial multiplier lanes, two multiplier bits per cycle while run is high
  localparam int SQ_STEPS  = (SAMPLE_WIDTH + 1) / 2;
  localparam int MUL_STEPS = (SQ_STEPS > 8) ? SQ_STEPS : 8;
  localparam int MPLR_W    = 2 * MUL_STEPS;
  localparam int MCAND_W   = 33;
  localparam int ACC_W     = MCAND_W + MPLR_W;
  localparam int PRD_W     = THR_W + AVG_W;

  localparam int STEP_MAX = (MUL_STEPS > ROOT_STEPS) ? MUL_STEPS : ROOT_STEPS;
  localparam int STEP_W   = $clog2(STEP_MAX);

  // taper coefficients, Q1.15
  localparam int COEF_W     = 16;
  localparam int TAPER_FRAC = 15;
  localparam logic [ACC_W-1:0] TAPER_ROUND = ACC_W'(16384);

  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic load;
    logic run;
  } step_ctrl_t;

  localparam coef_t TAPER3 [16] = '{
    16'd0,     16'd16384, 16'd0,     16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384,
    16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384};
  localparam coef_t TAPER7 [16] = '{
    16'd0,     16'd19661, 16'd9830,  16'd0,     16'd0,     16'd0,     16'd9830,  16'd19661,
    16'd19661, 16'd19661, 16'd19661, 16'd19661, 16'd19661, 16'd19661, 16'd19661, 16'd19661};
  localparam coef_t TAPER15 [16] = '{
    16'd0,     16'd26214, 16'd19661, 16'd13107, 16'd6554,  16'd0,     16'd0,     16'd0,
    16'd0,     16'd0,     16'd0,     16'd0,     16'd6554,  16'd13107, 16'd19661, 16'd26214};

  function automatic logic [CNT_W-1:0] hang_len(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_HANG3:  hang_len = 4'd3;
      MODE_HANG15: hang_len = 4'd15;
      default:     hang_len = 4'd7;
    endcase
  endfunction

  function automatic coef_t taper(input logic [MODE_W-1:0] mode,
                                  input logic [CNT_W-1:0] k);
    case (mode)
      MODE_HANG3:  taper = TAPER3[k];
      MODE_HANG15: taper = TAPER15[k];
      default:     taper = TAPER7[k];
    endcase
  endfunction

endpackage

### sv/ibh_dmul.sv
// ----------------------------------------------------------------------------
// ibh_dmul
// Digit-serial multiplier lane: signed multiplicand times unsigned multiplier,
// two multiplier bits per cycle while run is high, most significant digit first.
// ----------------------------------------------------------------------------
module ibh_dmul (
  input  logic                               clk,
  input  ibh_pkg::step_ctrl_t                ctrl,
  input  logic signed [ibh_pkg::MCAND_W-1:0] mcand,
  input  logic        [ibh_pkg::MPLR_W-1:0]  mplr,
  output logic signed [ibh_pkg::ACC_W-1:0]   prod
);

  logic signed [ibh_pkg::MCAND_W-1:0] mcand_r;
  logic        [ibh_pkg::MPLR_W-1:0]  mplr_r;
  logic signed [ibh_pkg::ACC_W-1:0]   acc_r;
  logic signed [ibh_pkg::ACC_W-1:0]   acc_nxt;
  logic signed [ibh_pkg::ACC_W-1:0]   mc_ext;
  logic signed [ibh_pkg::ACC_W-1:0]   addend;
  logic        [1:0]                  digit;

  always_comb begin
    mc_ext = ibh_pkg::ACC_W'(mcand_r);
    digit  = mplr_r[ibh_pkg::MPLR_W-1 -: 2];
    case (digit)
      2'd0:    addend = '0;
      2'd1:    addend = mc_ext;
      2'd2:    addend = mc_ext <<< 1;
      2'd3:    addend = mc_ext + (mc_ext <<< 1);
      default: addend = '0;
    endcase
    acc_nxt = (acc_r <<< 2) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand_r <= mcand;
      mplr_r  <= mplr;
      acc_r   <= '0;
    end else if (ctrl.run) begin
      mplr_r <= mplr_r << 2;
      acc_r  <= acc_nxt;
    end
  end

  assign prod = acc_r;

endmodule

### sv/ibh_isqrt.sv
// ----------------------------------------------------------------------------
// ibh_isqrt
// Restoring integer square root, two result bits per cycle while run is high.
// ----------------------------------------------------------------------------
module ibh_isqrt (
  input  logic                             clk,
  input  ibh_pkg::step_ctrl_t              ctrl,
  input  logic [ibh_pkg::X_W-1:0]          x_in,
  output logic [ibh_pkg::ROOT_BITS-1:0]    root
);

  logic [ibh_pkg::X_W-1:0]       x_r;
  logic [ibh_pkg::REM_W-1:0]     rem_r;
  logic [ibh_pkg::ROOT_BITS-1:0] root_r;
  logic [ibh_pkg::X_W-1:0]       x_nxt;
  logic [ibh_pkg::REM_W-1:0]     rem_nxt;
  logic [ibh_pkg::ROOT_BITS-1:0] root_nxt;
  logic [ibh_pkg::REM_W+1:0]     sh;
  logic [ibh_pkg::REM_W+1:0]     trial;
  logic [ibh_pkg::REM_W+1:0]     diff;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    sh       = '0;
    trial    = '0;
    diff     = '0;
    for (int s = 0; s < 2; s++) begin
      sh    = {rem_nxt, x_nxt[ibh_pkg::X_W-1 -: 2]};
      trial = {{(ibh_pkg::REM_W - ibh_pkg::ROOT_BITS){1'b0}}, root_nxt, 2'b01};
      diff  = sh - trial;
      if (sh >= trial) begin
        rem_nxt  = diff[ibh_pkg::REM_W-1:0];
        root_nxt = {root_nxt[ibh_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = sh[ibh_pkg::REM_W-1:0];
        root_nxt = {root_nxt[ibh_pkg::ROOT_BITS-2:0], 1'b0};
      end
      x_nxt = x_nxt << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r    <= x_in;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctrl.run) begin
      x_r    <= x_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;

endmodule

### sv/impulse_blanker_hang_shaped.sv
// an accepted item passes SQ, SUM, ROOT, AVGA, AVGB, CMP and DONE in turn before
//   out_valid rises; an output stall can hold it in DONE. One item at a time:
//   two passes of the serial multiplier lanes and the root set the interval
// a finished item waits in the output register; the next item is taken once it is there
// reset (rst_n low, synchronous): registers to their reset values, delay ring
//   cleared, average to 1.0, hang idle; no clearing pass afterwards
// ----------------------------------------------------------------------------
// impulse_blanker_hang_shaped
// Complex impulse blanker: magnitude against a running average starts a
// hang during which the sample is tapered, otherwise a delayed sample passes.
// ----------------------------------------------------------------------------
module impulse_blanker_hang_shaped (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [ibh_pkg::SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic signed [ibh_pkg::SAMPLE_WIDTH-1:0] in_sample_q,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ibh_pkg::SAMPLE_WIDTH-1:0] out_i,
  output logic signed [ibh_pkg::SAMPLE_WIDTH-1:0] out_q,
  output logic                                    out_blanking,
  input  logic                                    cfg_wr_en,
  input  logic [ibh_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ibh_pkg::CFG_W-1:0]               cfg_wdata
);

  localparam int W = ibh_pkg::SAMPLE_WIDTH;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_ROOT = 8'b0000_1000,
    ST_AVGA = 8'b0001_0000,
    ST_AVGB = 8'b0010_0000,
    ST_CMP  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [ibh_pkg::STEP_W-1:0] step_r, step_nxt;

  logic [ibh_pkg::THR_W-1:0]  thr_r;
  logic [ibh_pkg::MODE_W-1:0] mode_r;
  logic [ibh_pkg::DLY_W-1:0]  dly_r;

  logic [W-1:0] ring_i_r [ibh_pkg::RING_DEPTH];
  logic [W-1:0] ring_q_r [ibh_pkg::RING_DEPTH];

  logic [ibh_pkg::PTR_W-1:0]   wp_r;
  logic [ibh_pkg::RING_AW-1:0] ridx_r;
  logic [ibh_pkg::CNT_W-1:0]   cnt_r;
  logic [ibh_pkg::AVG_W-1:0]   avg_r;
  logic [ibh_pkg::MAG_W-1:0]   mag_r;
  logic                        clip_r;
  logic [ibh_pkg::AVGT_W-1:0]  k_r;

  logic                        out_valid_r;
  logic [W-1:0]                out_i_r;
  logic [W-1:0]                out_q_r;
  logic                        out_blank_r;

  logic                        accept;
  logic                        finish;
  logic [ibh_pkg::CNT_W-1:0]   len;
  logic [ibh_pkg::DLY_W-1:0]   dly_sat;
  logic [ibh_pkg::PTR_W-1:0]   wmask;
  logic [ibh_pkg::RING_AW-1:0] widx;
  logic [ibh_pkg::RPTR_W-1:0]  rptr;
  logic [ibh_pkg::PTR_W-1:0]   wp_nxt;
  logic [ibh_pkg::CNT_W-1:0]   coef_k;
  ibh_pkg::coef_t              coef;
  logic [W-1:0]                abs_i;
  logic [W-1:0]                abs_q;

  ibh_pkg::step_ctrl_t               ctl0, ctl_in, ctl_root;
  logic signed [ibh_pkg::MCAND_W-1:0] mc0, mc1, mc2, mc3;
  logic        [ibh_pkg::MPLR_W-1:0]  mp0, mp1, mp_coef;
  logic signed [ibh_pkg::ACC_W-1:0]   p0, p1, p2, p3;

  logic [ibh_pkg::SUM_W-1:0]     sum;
  logic [ibh_pkg::SHX_W-1:0]     shx;
  logic [ibh_pkg::ROOT_BITS-1:0] root;
  logic [ibh_pkg::MAG_W-1:0]     mag;
  logic [ibh_pkg::AVGT_W-1:0]    k_nxt;
  logic [ibh_pkg::AVGT_W-1:0]    avg_t;
  logic [ibh_pkg::AVG_W-1:0]     avg_new;
  logic [ibh_pkg::PRD_W-1:0]     thr_prod;
  logic [ibh_pkg::PRD_W-1:0]     mag_sh;
  logic                          trig;
  logic [ibh_pkg::CNT_W-1:0]     cnt_eff;
  logic                          blank;
  logic [ibh_pkg::ACC_W-1:0]     ti;
  logic [ibh_pkg::ACC_W-1:0]     tq;

  // front end: pointers and taper choice for the arriving item
  always_comb begin
    accept  = in_valid && (state_r == ST_IDLE);
    len     = ibh_pkg::hang_len(mode_r);
    dly_sat = (dly_r > ibh_pkg::DELAY_MAX) ? ibh_pkg::DELAY_MAX : dly_r;
    wmask   = wp_r & len;
    widx    = wmask[ibh_pkg::RING_AW-1:0];
    rptr    = (ibh_pkg::RPTR_W'(wp_r) + dly_sat) & {1'b0, len};
    wp_nxt  = (wp_r + len) & len;
    coef_k  = (cnt_r != '0) ? cnt_r : len;
    coef    = ibh_pkg::taper(mode_r, coef_k);
    abs_i   = in_sample_i[W-1] ? (~in_sample_i + 1'b1) : in_sample_i;
    abs_q   = in_sample_q[W-1] ? (~in_sample_q + 1'b1) : in_sample_q;
  end

  // lane operands
  always_comb begin
    if (state_r == ST_AVGB) begin
      mc0 = ibh_pkg::MCAND_W'(avg_new);
      mp0 = ibh_pkg::MPLR_W'(thr_r);
    end else begin
      mc0 = ibh_pkg::MCAND_W'(abs_i);
      mp0 = ibh_pkg::MPLR_W'(abs_i);
    end
    mc1      = ibh_pkg::MCAND_W'(abs_q);
    mp1      = ibh_pkg::MPLR_W'(abs_q);
    mc2      = ibh_pkg::MCAND_W'(in_sample_i);
    mc3      = ibh_pkg::MCAND_W'(in_sample_q);
    mp_coef  = ibh_pkg::MPLR_W'(coef);
    ctl0.load     = accept || (state_r == ST_AVGB);
    ctl0.run      = (state_r == ST_SQ) || (state_r == ST_CMP);
    ctl_in.load   = accept;
    ctl_in.run    = (state_r == ST_SQ);
    ctl_root.load = (state_r == ST_SUM);
    ctl_root.run  = (state_r == ST_ROOT);
  end

  ibh_dmul u_mul_sqi (.clk(clk), .ctrl(ctl0),   .mcand(mc0), .mplr(mp0),     .prod(p0));
  ibh_dmul u_mul_sqq (.clk(clk), .ctrl(ctl_in), .mcand(mc1), .mplr(mp1),     .prod(p1));
  ibh_dmul u_mul_tpi (.clk(clk), .ctrl(ctl_in), .mcand(mc2), .mplr(mp_coef), .prod(p2));
  ibh_dmul u_mul_tpq (.clk(clk), .ctrl(ctl_in), .mcand(mc3), .mplr(mp_coef), .prod(p3));

  // magnitude, average and trigger
  always_comb begin
    sum = ibh_pkg::SUM_W'(p0[2*W-1:0]) + ibh_pkg::SUM_W'(p1[2*W-1:0]);
    shx = {sum, {ibh_pkg::SQ_SHIFT{1'b0}}};
    mag = clip_r ? ibh_pkg::CLIP_MAG : root;
    // avg * 65470 = avg * 65536 - avg * 66
    k_nxt = ibh_pkg::AVGT_W'({avg_r, {ibh_pkg::AVG_FRAC{1'b0}}})
          - ibh_pkg::AVGT_W'({avg_r, 6'b0}) - ibh_pkg::AVGT_W'({avg_r, 1'b0});
    avg_t = k_r + ibh_pkg::AVGT_W'({mag_r, 6'b0}) + ibh_pkg::AVGT_W'({mag_r, 1'b0})
          + ibh_pkg::AVG_ROUND;
    avg_new  = avg_t[ibh_pkg::AVG_W+ibh_pkg::AVG_FRAC-1:ibh_pkg::AVG_FRAC];
    thr_prod = p0[ibh_pkg::PRD_W-1:0];
    mag_sh   = ibh_pkg::PRD_W'({mag_r, 8'b0});
    trig     = (cnt_r == '0) && (mag_sh > thr_prod);
    cnt_eff  = trig ? len : cnt_r;
    blank    = (cnt_eff != '0);
    ti       = p2 + ibh_pkg::TAPER_ROUND;
    tq       = p3 + ibh_pkg::TAPER_ROUND;
    finish   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  ibh_isqrt u_isqrt (
    .clk  (clk),
    .ctrl (ctl_root),
    .x_in (shx[ibh_pkg::X_W-1:0]),
    .root (root)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SQ;
          step_nxt  = ibh_pkg::STEP_W'(ibh_pkg::MUL_STEPS - 1);
        end
      end
      ST_SQ: begin
        if (step_r == '0) state_nxt = ST_SUM;
        else step_nxt = step_r - 1'b1;
      end
      ST_SUM: begin
        state_nxt = ST_ROOT;
        step_nxt  = ibh_pkg::STEP_W'(ibh_pkg::ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        if (step_r == '0) state_nxt = ST_AVGA;
        else step_nxt = step_r - 1'b1;
      end
      ST_AVGA: state_nxt = ST_AVGB;
      ST_AVGB: begin
        state_nxt = ST_CMP;
        step_nxt  = ibh_pkg::STEP_W'(ibh_pkg::MUL_STEPS - 1);
      end
      ST_CMP: begin
        if (step_r == '0) state_nxt = ST_DONE;
        else step_nxt = step_r - 1'b1;
      end
      ST_DONE: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ibh_pkg::THR_RESET;
      mode_r <= ibh_pkg::MODE_RESET;
      dly_r  <= ibh_pkg::DLY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ibh_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata[ibh_pkg::THR_W-1:0];
        ibh_pkg::CFG_HANG_MODE: mode_r <= cfg_wdata[ibh_pkg::MODE_W-1:0];
        ibh_pkg::CFG_DELAY:     dly_r  <= cfg_wdata[ibh_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // delay ring and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ibh_pkg::RING_DEPTH; e++) begin
        ring_i_r[e] <= '0;
        ring_q_r[e] <= '0;
      end
      wp_r   <= '0;
      ridx_r <= '0;
      cnt_r  <= '0;
      avg_r  <= ibh_pkg::AVG_ONE;
    end else begin
      if (accept) begin
        ring_i_r[widx] <= in_sample_i;
        ring_q_r[widx] <= in_sample_q;
        ridx_r         <= rptr[ibh_pkg::RING_AW-1:0];
        wp_r           <= wp_nxt;
      end
      if (state_r == ST_AVGB) avg_r <= avg_new;
      if (finish && blank) cnt_r <= cnt_eff - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) clip_r <= (sum >= ibh_pkg::CLIP_SUM);
    if (state_r == ST_AVGA) begin
      mag_r <= mag;
      k_r   <= k_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_blank_r <= blank;
      if (blank) begin
        out_i_r <= ti[ibh_pkg::TAPER_FRAC +: W];
        out_q_r <= tq[ibh_pkg::TAPER_FRAC +: W];
      end else begin
        out_i_r <= ring_i_r[ridx_r];
        out_q_r <= ring_q_r[ridx_r];
      end
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_i        = out_i_r;
  assign out_q        = out_q_r;
  assign out_blanking = out_blank_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SQ))
    else $error("accepted item did not start the square pass");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid)
    else $error("finished item not presented");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_AVGA) && !clip_r) |-> (root <= ibh_pkg::CLIP_MAG))
    else $error("unclipped root above clip level");

  a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SQ) || (state_r == ST_CMP))
      |-> (step_r <= ibh_pkg::STEP_W'(ibh_pkg::MUL_STEPS - 1)))
    else $error("multiplier step count out of range");
`endif

endmodule
